[sv/utf8_pkg.sv]
// shared types and constants for the utf8 identity validator
package utf8_pkg;

    // range allowed for the next continuation byte
    typedef enum logic [2:0] {
        CLS_ANY   = 3'd0,   // 80..bf
        CLS_A0_BF = 3'd1,   // after e0
        CLS_80_9F = 3'd2,   // after ed, keeps surrogates out
        CLS_90_BF = 3'd3,   // after f0
        CLS_80_8F = 3'd4    // after f4, caps at u+10ffff
    } cont_class_t;

    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_TOO_LONG  = 2'd1,
        VERDICT_MALFORMED = 2'd2,
        VERDICT_FORBIDDEN = 2'd3
    } verdict_t;

    // register byte addresses
    localparam logic [2:0] ADDR_IDENTITY_RULES = 3'd0;
    localparam logic [2:0] ADDR_MAX_LENGTH     = 3'd4;

    localparam logic       IDENTITY_RULES_RESET = 1'b1;
    localparam logic [7:0] MAX_LENGTH_RESET     = 8'd128;

    localparam logic [7:0] ASCII_MAX      = 8'h7f;
    localparam logic [7:0] LEAD2_MIN      = 8'hc2;
    localparam logic [7:0] LEAD2_MAX      = 8'hdf;
    localparam logic [7:0] LEAD3_E0       = 8'he0;
    localparam logic [7:0] LEAD3_ED       = 8'hed;
    localparam logic [7:0] LEAD3_MAX      = 8'hef;
    localparam logic [7:0] LEAD4_F0       = 8'hf0;
    localparam logic [7:0] LEAD4_F4       = 8'hf4;
    localparam logic [7:0] CONT_MIN       = 8'h80;
    localparam logic [7:0] CONT_MAX       = 8'hbf;
    localparam logic [7:0] CONT_A0        = 8'ha0;
    localparam logic [7:0] CONT_9F        = 8'h9f;
    localparam logic [7:0] CONT_90        = 8'h90;
    localparam logic [7:0] CONT_8F        = 8'h8f;
    localparam logic [7:0] CONTROL_LIMIT  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] COUNT_MAX      = 8'hff;

endpackage

[sv/utf8_identity_validator.sv]
// streaming strict utf-8 and identity string checker, top level
//
// channel   dir  handshake                 payload
// -------   ---  ------------------------  ---------------------------------------
// s_axis    in   s_axis_tvalid/tready      tdata = data_byte, tlast = end_of_string
// m_axis    out  m_axis_tvalid/tready      tdata = string_ok, tuser = verdict,
//                                          tlast = string_done
// apb       in   psel/penable/pready       reg 0 identity_rules, reg 4 max_length
//
// one result per request, one request per cycle while s_axis_tready is high; the per-byte
// decode and state update sit between the string state registers and the
// result register, so each result leaves from a register
// a two-entry output (result register plus skid) keeps s_axis_tready high
// while a result is held downstream and drops it only when both are full
// rst_n clears the string state and the output valids and resets the registers to their defaults
module utf8_identity_validator
    import utf8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] string_ok, [7:1] zero
    output logic [1:0] m_axis_tuser,   // [1:0] verdict
    output logic       m_axis_tlast,

    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    // configuration registers
    logic       identity_rules_reg;
    logic [7:0] max_length_reg;

    // string state
    logic [1:0]  pending_reg, pending_next;
    cont_class_t class_reg, class_next;
    logic        bad_reg, bad_next;
    logic        forbidden_reg, forbidden_next;
    logic [7:0]  count_reg, count_next;

    // output register and skid stage
    logic     out_valid_reg, out_valid_next;
    logic     out_ok_reg;
    verdict_t out_verdict_reg;
    logic     out_last_reg;
    logic     skid_valid_reg, skid_valid_next;
    logic     skid_ok_reg;
    verdict_t skid_verdict_reg;
    logic     skid_last_reg;

    logic     in_fire;
    logic     cfg_write;
    logic     cont_ok;
    logic     too_long, malformed, forbidden_rep;
    logic     res_ok;
    verdict_t res_verdict;
    logic     load_out, load_skid, move_skid;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr)
            ADDR_IDENTITY_RULES: prdata = {31'd0, identity_rules_reg};
            ADDR_MAX_LENGTH:     prdata = {24'd0, max_length_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            identity_rules_reg <= IDENTITY_RULES_RESET;
            max_length_reg     <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr == ADDR_IDENTITY_RULES)
            begin
                identity_rules_reg <= pwdata[0];
            end
            if (paddr == ADDR_MAX_LENGTH)
            begin
                max_length_reg <= pwdata[7:0];
            end
        end
    end

    // input side stalls only when the skid stage holds a result
    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // continuation byte range check for the current class
    always_comb
    begin
        unique case (class_reg)
            CLS_A0_BF: cont_ok = (s_axis_tdata >= CONT_A0) && (s_axis_tdata <= CONT_MAX);
            CLS_80_9F: cont_ok = (s_axis_tdata >= CONT_MIN) && (s_axis_tdata <= CONT_9F);
            CLS_90_BF: cont_ok = (s_axis_tdata >= CONT_90) && (s_axis_tdata <= CONT_MAX);
            CLS_80_8F: cont_ok = (s_axis_tdata >= CONT_MIN) && (s_axis_tdata <= CONT_8F);
            default:   cont_ok = (s_axis_tdata >= CONT_MIN) && (s_axis_tdata <= CONT_MAX);
        endcase
    end

    // decode step and verdict for the byte on the input
    always_comb
    begin
        pending_next   = pending_reg;
        class_next     = class_reg;
        bad_next       = bad_reg;
        forbidden_next = forbidden_reg;

        if (pending_reg != 2'd0)
        begin
            class_next = CLS_ANY;
            if (cont_ok)
            begin
                pending_next = pending_reg - 2'd1;
            end
            else
            begin
                // bad continuation: flag it, next byte starts over as a lead
                bad_next     = 1'b1;
                pending_next = 2'd0;
            end
        end
        else if (s_axis_tdata <= ASCII_MAX)
        begin
            pending_next = 2'd0;
        end
        else if ((s_axis_tdata >= LEAD2_MIN) && (s_axis_tdata <= LEAD2_MAX))
        begin
            pending_next = 2'd1;
            class_next   = CLS_ANY;
        end
        else if (s_axis_tdata == LEAD3_E0)
        begin
            pending_next = 2'd2;
            class_next   = CLS_A0_BF;
        end
        else if (s_axis_tdata == LEAD3_ED)
        begin
            pending_next = 2'd2;
            class_next   = CLS_80_9F;
        end
        else if ((s_axis_tdata > LEAD3_E0) && (s_axis_tdata <= LEAD3_MAX))
        begin
            pending_next = 2'd2;
            class_next   = CLS_ANY;
        end
        else if (s_axis_tdata == LEAD4_F0)
        begin
            pending_next = 2'd3;
            class_next   = CLS_90_BF;
        end
        else if ((s_axis_tdata > LEAD4_F0) && (s_axis_tdata < LEAD4_F4))
        begin
            pending_next = 2'd3;
            class_next   = CLS_ANY;
        end
        else if (s_axis_tdata == LEAD4_F4)
        begin
            pending_next = 2'd3;
            class_next   = CLS_80_8F;
        end
        else
        begin
            // stray continuation, c0/c1 overlong leads, f5 and up
            bad_next = 1'b1;
        end

        if ((s_axis_tdata < CONTROL_LIMIT) || (s_axis_tdata == CHAR_QUOTE)
            || (s_axis_tdata == CHAR_BACKSLASH))
        begin
            forbidden_next = 1'b1;
        end

        // length includes this byte; count saturates so huge strings stay long
        too_long      = identity_rules_reg
                        && (({1'b0, count_reg} + 9'd1) > {1'b0, max_length_reg});
        malformed     = bad_next || (s_axis_tlast && (pending_next != 2'd0));
        forbidden_rep = identity_rules_reg && forbidden_next;

        if (too_long)
        begin
            res_verdict = VERDICT_TOO_LONG;
        end
        else if (malformed)
        begin
            res_verdict = VERDICT_MALFORMED;
        end
        else if (forbidden_rep)
        begin
            res_verdict = VERDICT_FORBIDDEN;
        end
        else
        begin
            res_verdict = VERDICT_OK;
        end
        res_ok = (res_verdict == VERDICT_OK);

        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;

        // final byte clears everything for the next string
        if (s_axis_tlast)
        begin
            pending_next   = 2'd0;
            class_next     = CLS_ANY;
            bad_next       = 1'b0;
            forbidden_next = 1'b0;
            count_next     = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            class_reg     <= CLS_ANY;
            bad_reg       <= 1'b0;
            forbidden_reg <= 1'b0;
            count_reg     <= 8'd0;
        end
        else if (in_fire)
        begin
            pending_reg   <= pending_next;
            class_reg     <= class_next;
            bad_reg       <= bad_next;
            forbidden_reg <= forbidden_next;
            count_reg     <= count_next;
        end
    end

    // output register and skid control
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        move_skid       = 1'b0;

        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                move_skid       = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                load_out       = in_fire;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (move_skid)
        begin
            out_ok_reg      <= skid_ok_reg;
            out_verdict_reg <= skid_verdict_reg;
            out_last_reg    <= skid_last_reg;
        end
        else if (load_out)
        begin
            out_ok_reg      <= res_ok;
            out_verdict_reg <= res_verdict;
            out_last_reg    <= s_axis_tlast;
        end
        if (load_skid)
        begin
            skid_ok_reg      <= res_ok;
            skid_verdict_reg <= res_verdict;
            skid_last_reg    <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_ok_reg};
    assign m_axis_tuser  = out_verdict_reg;
    assign m_axis_tlast  = out_last_reg;

    // skid stage is only filled behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    // no class restriction survives once a sequence is closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 2'd0) |-> (class_reg == CLS_ANY))
        else $error("continuation class left set with no sequence open");

    // final byte leaves the string state clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=>
            ((count_reg == 8'd0) && (pending_reg == 2'd0) && !bad_reg && !forbidden_reg))
        else $error("string state not cleared after the final byte");

    // ok flag agrees with the verdict code on every shown result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tuser == VERDICT_OK)))
        else $error("string_ok disagrees with verdict");

endmodule

[verif/tb_utf8_identity_validator.sv]
// testbench for the utf8 identity validator: random and directed strings against a predictor
module tb_utf8_identity_validator;
    import utf8_pkg::*;

    // watchdog: cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    // one input request: a string byte and its end mark
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    // what the block should report for one byte
    typedef struct {
        logic     done;
        logic     ok;
        verdict_t verdict;
    } string_result_t;

    // receiver back-pressure styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;   // end_of_string

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [0] string_ok, [7:1] zero
    logic [1:0]  m_axis_tuser;          // [1:0] verdict
    logic        m_axis_tlast;          // string_done

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // stimulus and scoreboard storage
    byte_req_t      byte_queue[$];
    string_result_t expected_results[$];
    byte_req_t      next_req;
    bit             hold_sender = 1'b0;
    int             burst_left = 0;
    int             gap_left = 0;
    int             fail_count = 0;
    int             result_index = 0;
    int             idle_cycles = 0;

    // receiver pattern state
    rx_mode_t       rx_mode = RX_OPEN;
    int             mode_left = 0;

    // predictor copy of the registers and the per-string state
    logic           cfg_rules = IDENTITY_RULES_RESET;
    logic [7:0]     cfg_max_len = MAX_LENGTH_RESET;
    logic [1:0]     pend_cont = '0;
    cont_class_t    next_class = CLS_ANY;
    logic           enc_bad = 1'b0;
    logic           forbid_seen = 1'b0;
    logic [7:0]     seen_count = '0;

    utf8_identity_validator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // is b allowed as the next continuation byte under class c
    function automatic logic cont_fits(input logic [7:0] b, input cont_class_t c);
        case (c)
            CLS_A0_BF: return b >= CONT_A0 && b <= CONT_MAX;
            CLS_80_9F: return b >= CONT_MIN && b <= CONT_9F;
            CLS_90_BF: return b >= CONT_90 && b <= CONT_MAX;
            CLS_80_8F: return b >= CONT_MIN && b <= CONT_8F;
            default:   return b >= CONT_MIN && b <= CONT_MAX;
        endcase
    endfunction

    // advance the string state by one byte and work out the verdict it yields
    function automatic string_result_t judge_byte(input logic [7:0] b, input logic last);
        int unsigned    length;
        logic           too_long;
        logic           malformed;
        logic           forbidden;
        string_result_t r;
        length = int'(seen_count) + 1;
        if (pend_cont != 0)
        begin
            // inside a sequence: a byte out of range breaks it and restarts decoding
            if (cont_fits(b, next_class))
                pend_cont = pend_cont - 2'd1;
            else
            begin
                enc_bad = 1'b1;
                pend_cont = 2'd0;
            end
            next_class = CLS_ANY;
        end
        else if (b <= ASCII_MAX)
            ;
        else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
        begin
            pend_cont = 2'd1;
            next_class = CLS_ANY;
        end
        else if (b == LEAD3_E0)
        begin
            // keeps out overlong three-byte forms
            pend_cont = 2'd2;
            next_class = CLS_A0_BF;
        end
        else if (b == LEAD3_ED)
        begin
            // keeps out surrogates
            pend_cont = 2'd2;
            next_class = CLS_80_9F;
        end
        else if (b > LEAD3_E0 && b <= LEAD3_MAX)
        begin
            pend_cont = 2'd2;
            next_class = CLS_ANY;
        end
        else if (b == LEAD4_F0)
        begin
            pend_cont = 2'd3;
            next_class = CLS_90_BF;
        end
        else if (b > LEAD4_F0 && b < LEAD4_F4)
        begin
            pend_cont = 2'd3;
            next_class = CLS_ANY;
        end
        else if (b == LEAD4_F4)
        begin
            // nothing above u+10ffff
            pend_cont = 2'd3;
            next_class = CLS_80_8F;
        end
        else
            enc_bad = 1'b1;

        if (b < CONTROL_LIMIT || b == CHAR_QUOTE || b == CHAR_BACKSLASH)
            forbid_seen = 1'b1;
        if (seen_count != COUNT_MAX)
            seen_count = seen_count + 8'd1;

        // flags are tracked either way, identity rules only decide whether they count
        too_long  = cfg_rules && length > int'(cfg_max_len);
        malformed = enc_bad || (last && pend_cont != 0);
        forbidden = cfg_rules && forbid_seen;

        if (too_long)
            r.verdict = VERDICT_TOO_LONG;
        else if (malformed)
            r.verdict = VERDICT_MALFORMED;
        else if (forbidden)
            r.verdict = VERDICT_FORBIDDEN;
        else
            r.verdict = VERDICT_OK;
        r.done = last;
        r.ok = (r.verdict == VERDICT_OK);

        if (last)
        begin
            pend_cont = 2'd0;
            next_class = CLS_ANY;
            enc_bad = 1'b0;
            forbid_seen = 1'b0;
            seen_count = '0;
        end
        return r;
    endfunction

    // sender: bursts of random length, random gaps between them, plus an explicit hold
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (hold_sender || byte_queue.size() == 0)
                s_axis_tvalid <= 1'b0;
            else
            begin
                next_req = byte_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_req.data;
                s_axis_tlast <= next_req.last;
                // end of a burst: pick the gap that follows and the next burst length
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver: back-pressure style changes whenever its random mode counter runs out
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 160);
            end
            else
                mode_left <= mode_left - 1;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= (mode_left[2:0] < 3);
            endcase
        end
    end

    // monitor: predict on each accepted byte, then check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(judge_byte(s_axis_tdata, s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result %0d arrived with nothing expected: ",
                                  "tdata %h tuser %0d tlast %0b"},
                                 result_index, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else if (m_axis_tlast !== expected_results[0].done
                         || m_axis_tdata !== {7'b0, expected_results[0].ok}
                         || m_axis_tuser !== expected_results[0].verdict)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result %0d mismatch: expected done %0b ok %0b %s, ",
                                  "got tlast %0b tdata %h tuser %0d"},
                                 result_index, expected_results[0].done, expected_results[0].ok,
                                 expected_results[0].verdict.name(), m_axis_tlast, m_axis_tdata,
                                 m_axis_tuser);
                end
                if (expected_results.size() != 0)
                    void'(expected_results.pop_front());
                result_index++;
            end
        end
    end

    // watchdog: any handshake or register access counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_utf8_identity_validator failed");
                $finish;
            end
        end
    end

    // register write: setup then access, mirrored into the predictor at the write edge
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_IDENTITY_RULES: cfg_rules = value[0];
            ADDR_MAX_LENGTH:     cfg_max_len = value[7:0];
            default: ;
        endcase
    endtask

    // block is idle: every byte sent and every result back
    task automatic wait_drained();
        while (byte_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // up to four bytes, first byte in the low bits
    task automatic put_str(input logic [31:0] bytes, input int count, input logic closes);
        byte_req_t req;
        for (int i = 0; i < count; i++)
        begin
            req.data = bytes[8*i +: 8];
            req.last = closes && (i == count - 1);
            byte_queue.push_back(req);
        end
    endtask

    // random byte in lo..hi
    function automatic logic [7:0] rand_byte(input logic [7:0] lo, input logic [7:0] hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    function automatic logic [7:0] any_cont();
        return rand_byte(CONT_MIN, CONT_MAX);
    endfunction

    // one character, well-formed unless noise is allowed and picked
    task automatic append_char(ref logic [7:0] str[$], input bit noisy);
        int unsigned pick;
        logic [7:0]  lead;
        pick = noisy ? $urandom_range(0, 99) : $urandom_range(0, 89);
        if (pick < 45)
            str.push_back(rand_byte(8'h20, 8'h7e));
        else if (pick < 50)
        begin
            // characters the identity rules reject
            case ($urandom_range(0, 3))
                0, 1:    str.push_back(rand_byte(8'h00, 8'h1f));
                2:       str.push_back(CHAR_QUOTE);
                default: str.push_back(CHAR_BACKSLASH);
            endcase
        end
        else if (pick < 65)
        begin
            str.push_back(rand_byte(LEAD2_MIN, LEAD2_MAX));
            str.push_back(any_cont());
        end
        else if (pick < 78)
        begin
            lead = rand_byte(LEAD3_E0, LEAD3_MAX);
            str.push_back(lead);
            if (lead == LEAD3_E0)
                str.push_back(rand_byte(CONT_A0, CONT_MAX));
            else if (lead == LEAD3_ED)
                str.push_back(rand_byte(CONT_MIN, CONT_9F));
            else
                str.push_back(any_cont());
            str.push_back(any_cont());
        end
        else if (pick < 90)
        begin
            lead = rand_byte(LEAD4_F0, LEAD4_F4);
            str.push_back(lead);
            if (lead == LEAD4_F0)
                str.push_back(rand_byte(CONT_90, CONT_MAX));
            else if (lead == LEAD4_F4)
                str.push_back(rand_byte(CONT_MIN, CONT_8F));
            else
                str.push_back(any_cont());
            str.push_back(any_cont());
            str.push_back(any_cont());
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: str.push_back(rand_byte(8'h00, 8'hff));
                // stray continuation byte
                1: str.push_back(any_cont());
                // lead bytes that never occur in utf-8
                2: str.push_back($urandom_range(0, 1) ? rand_byte(8'hc0, 8'hc1)
                                                      : rand_byte(8'hf5, 8'hff));
                // lead with its tail cut short by whatever comes next
                3: str.push_back(rand_byte(LEAD2_MIN, LEAD4_F4));
                default:
                begin
                    // second byte just outside the allowed range
                    case ($urandom_range(0, 4))
                        0:
                        begin
                            str.push_back(LEAD3_E0);
                            str.push_back(rand_byte(CONT_MIN, CONT_9F));
                        end
                        1:
                        begin
                            str.push_back(LEAD3_ED);
                            str.push_back(rand_byte(CONT_A0, CONT_MAX));
                        end
                        2:
                        begin
                            str.push_back(LEAD4_F0);
                            str.push_back(rand_byte(CONT_MIN, CONT_8F));
                        end
                        3:
                        begin
                            str.push_back(LEAD4_F4);
                            str.push_back(rand_byte(CONT_90, CONT_MAX));
                        end
                        default:
                        begin
                            str.push_back(LEAD2_MIN);
                            str.push_back($urandom_range(0, 1) ? rand_byte(8'h00, ASCII_MAX)
                                                               : rand_byte(8'hc0, 8'hff));
                        end
                    endcase
                end
            endcase
        end
    endtask

    // string of exactly target_len bytes; trimming may leave a sequence open at the end
    task automatic queue_string(input int target_len, input bit noisy);
        logic [7:0] str[$];
        byte_req_t  req;
        while (str.size() < target_len)
            append_char(str, noisy);
        while (str.size() > target_len)
            void'(str.pop_back());
        foreach (str[i])
        begin
            req.data = str[i];
            req.last = (i == str.size() - 1);
            byte_queue.push_back(req);
        end
    endtask

    // mostly short strings, some around the length limit
    function automatic int pick_length(input int max_len);
        int roll;
        int around;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 10);
        if (roll < 85 && max_len <= 128)
        begin
            around = max_len + int'($urandom_range(0, 4)) - 2;
            return (around < 1) ? 1 : around;
        end
        return $urandom_range(1, 40);
    endfunction

    initial
    begin
        int         phase_bytes;
        int         len;
        int         hold_at;
        logic       rules;
        logic [7:0] max_len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: identity rules on, limit 128
        put_str(32'h41, 1, 1'b1);               // plain ascii
        put_str(32'h5c_22_1f, 3, 1'b1);         // control, quote, backslash
        put_str(32'h80_c2, 2, 1'b1);            // smallest two-byte form
        put_str(32'h80_9f_e0, 3, 1'b1);         // overlong three-byte
        put_str(32'h80_a0_ed, 3, 1'b1);         // surrogate
        put_str(32'h80_80_90_f4, 4, 1'b1);      // above u+10ffff
        put_str(32'hbf_bf_8f_f4, 4, 1'b1);      // u+10ffff itself
        put_str(32'h22_c1, 2, 1'b1);            // malformed wins over forbidden
        put_str(32'h80_e1, 2, 1'b1);            // sequence open at the end
        put_str(32'hff, 1, 1'b1);               // invalid lead alone

        // limit lowered while a string is open
        put_str(32'h63_62_61, 3, 1'b0);
        wait_drained();
        apb_write(ADDR_MAX_LENGTH, 32'd2);
        put_str(32'h64, 1, 1'b1);

        // limit of one: too long wins over everything, one byte fits exactly
        wait_drained();
        apb_write(ADDR_MAX_LENGTH, 32'd1);
        put_str(32'hff_22, 2, 1'b1);
        put_str(32'h41, 1, 1'b1);

        // limit of zero rejects every string
        wait_drained();
        apb_write(ADDR_MAX_LENGTH, 32'd0);
        put_str(32'h41, 1, 1'b1);

        // identity rules off: only encoding errors count
        wait_drained();
        apb_write(ADDR_IDENTITY_RULES, 32'd0);
        put_str(32'h22_c0, 2, 1'b1);
        put_str(32'h20_5c, 2, 1'b1);

        // random phases, one register setting each
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       begin rules = 1'b1; max_len = 8'd128; end
                1:       begin rules = 1'b0; max_len = 8'd128; end
                2:       begin rules = 1'b1; max_len = 8'd4;   end
                3:       begin rules = 1'b1; max_len = 8'd255; end
                4:       begin rules = 1'b1; max_len = 8'd1;   end
                5:       begin rules = 1'b0; max_len = 8'd0;   end
                6:       begin rules = 1'b1; max_len = 8'd16;  end
                default: begin rules = 1'b1; max_len = 8'($urandom_range(1, 255)); end
            endcase
            wait_drained();
            apb_write(ADDR_IDENTITY_RULES, {31'b0, rules});
            apb_write(ADDR_MAX_LENGTH, {24'b0, max_len});

            // byte counter saturation, and a string right at the widest limit
            if (max_len == 8'd255)
            begin
                queue_string(300, 1'b0);
                queue_string(255, 1'b0);
            end

            phase_bytes = 0;
            while (phase_bytes < 75)
            begin
                len = pick_length(max_len);
                queue_string(len, $urandom_range(0, 9) < 3);
                phase_bytes += len;
            end

            // sender holds off partway through until the block has caught up
            hold_at = $urandom_range(0, 60);
            while (byte_queue.size() > hold_at)
                @(negedge clk);
            hold_sender = 1'b1;
            while (expected_results.size() != 0 || s_axis_tvalid)
                @(negedge clk);
            hold_sender = 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_utf8_identity_validator passed");
        else
            $display("tb_utf8_identity_validator failed");
        $finish;
    end

endmodule
